// File: hdl/lks_pkg.sv
// Shared types and constants for the link key store.
package lks_pkg;

    localparam int ADDR_W = 48;
    localparam int HALF_W = 64;
    localparam int KIND_W = 8;
    localparam int SEQ_W  = 32;
    localparam int SLOT_W = 4;

    typedef enum logic [2:0] {
        MODE_LOOKUP = 3'd0,
        MODE_STORE  = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_REWIND = 3'd3,
        MODE_NEXT   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [HALF_W-1:0] key_upper;
        logic [HALF_W-1:0] key_lower;
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_num;
    } entry_t;

endpackage

// File: hdl/link_key_store_fifo_evict.sv
// Link key store with FIFO replacement: top level, slot scanner and entry memory.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------------------
//  request  | start / busy     | mode, address, key_upper, key_lower, key_kind
//  result   | done (1 cycle)   | found, found_address, found_key_upper,
//           |                  | found_key_lower, found_kind, slot_used
//
// A transaction is taken when start is high and busy is low. Lookup, store, delete
// and next sweep every slot through the registered entry memory, one slot per
// cycle; rewind and unused modes skip the sweep and go straight to the finish step.
// done is high in the cycle after the finish step, with busy already low.
// Reset clears the valid bits and the iterator at once; entry contents need no
// clearing. The result side cannot stall.
module link_key_store_fifo_evict
    import lks_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          mode,
    input  logic [ADDR_W-1:0]   address,
    input  logic [HALF_W-1:0]   key_upper,
    input  logic [HALF_W-1:0]   key_lower,
    input  logic [KIND_W-1:0]   key_kind,
    output logic                done,
    output logic                found,
    output logic [ADDR_W-1:0]   found_address,
    output logic [HALF_W-1:0]   found_key_upper,
    output logic [HALF_W-1:0]   found_key_lower,
    output logic [KIND_W-1:0]   found_kind,
    output logic [SLOT_W-1:0]   slot_used
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Entry memory: address, key, kind and sequence per slot. Written only in the
    // finish step and read only during the sweep, so no two accesses overlap.
    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [CNT_W-1:0] iter_reg;

    // Latched request.
    logic [2:0]        req_mode_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [HALF_W-1:0] req_ku_reg;
    logic [HALF_W-1:0] req_kl_reg;
    logic [KIND_W-1:0] req_kind_reg;

    // Sweep results.
    logic             hit_reg;       // first match (lookup, delete) or next valid entry
    logic [IDX_W-1:0] hit_idx_reg;
    logic             amatch_reg;    // last matching valid slot (store)
    logic [IDX_W-1:0] amatch_idx_reg;
    logic             empty_reg;     // last empty slot (store)
    logic [IDX_W-1:0] empty_idx_reg;
    logic             low_reg;       // first slot with lowest sequence (store)
    logic [IDX_W-1:0] low_idx_reg;
    logic [SEQ_W-1:0] low_seq_reg;
    logic [SEQ_W-1:0] high_seq_reg;
    entry_t           hit_data_reg;

    // Result registers.
    logic              done_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] found_address_reg;
    logic [HALF_W-1:0] found_key_upper_reg;
    logic [HALF_W-1:0] found_key_lower_reg;
    logic [KIND_W-1:0] found_kind_reg;
    logic [SLOT_W-1:0] slot_used_reg;

    logic             accept;
    logic             proc_en;
    logic [IDX_W-1:0] proc_idx;
    logic             proc_valid;
    logic             proc_match;
    logic             proc_after;
    logic             finish;
    logic [IDX_W-1:0] store_idx;
    logic             is_scan_mode;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign finish  = (state_reg == ST_FINISH);

    // Slot whose read data is present this cycle lags the read counter by one.
    assign proc_en    = (state_reg == ST_SCAN) && (cnt_reg != '0);
    assign proc_idx   = IDX_W'(cnt_reg - CNT_W'(1));
    assign proc_valid = valid_reg[proc_idx];
    assign proc_match = proc_valid && (rd_data_reg.address == req_addr_reg);
    assign proc_after = proc_valid && (CNT_W'(proc_idx) >= iter_reg);

    // Store target priority: existing address, then an empty slot, then the oldest.
    assign store_idx = amatch_reg ? amatch_idx_reg :
                       empty_reg  ? empty_idx_reg  : low_idx_reg;

    always_comb
    begin
        case (mode)
            MODE_LOOKUP, MODE_STORE, MODE_DELETE, MODE_NEXT: is_scan_mode = 1'b1;
            default:                                         is_scan_mode = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = is_scan_mode ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(SLOTS))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SCAN) && (cnt_reg < CNT_W'(SLOTS)))
            rd_data_reg <= mem[IDX_W'(cnt_reg)];
        if (finish && (req_mode_reg == MODE_STORE))
            mem[store_idx] <= '{address:   req_addr_reg,
                                key_upper: req_ku_reg,
                                key_lower: req_kl_reg,
                                kind:      req_kind_reg,
                                seq_num:   high_seq_reg + SEQ_W'(1)};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            valid_reg  <= '0;
            iter_reg   <= '0;
            hit_reg    <= 1'b0;
            amatch_reg <= 1'b0;
            empty_reg  <= 1'b0;
            low_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (accept)
            begin
                cnt_reg    <= '0;
                hit_reg    <= 1'b0;
                amatch_reg <= 1'b0;
                empty_reg  <= 1'b0;
                low_reg    <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (proc_en)
                begin
                    case (req_mode_reg)
                        MODE_LOOKUP, MODE_DELETE:
                            if (proc_match)
                                hit_reg <= 1'b1;
                        MODE_NEXT:
                            if (proc_after)
                                hit_reg <= 1'b1;
                        MODE_STORE:
                        begin
                            if (!proc_valid)
                                empty_reg <= 1'b1;
                            else
                            begin
                                low_reg <= 1'b1;
                                if (proc_match)
                                    amatch_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            else if (finish)
            begin
                case (req_mode_reg)
                    MODE_STORE:
                        valid_reg[store_idx] <= 1'b1;
                    MODE_DELETE:
                        if (hit_reg)
                            valid_reg[hit_idx_reg] <= 1'b0;
                    MODE_REWIND:
                        iter_reg <= '0;
                    MODE_NEXT:
                        iter_reg <= hit_reg ? CNT_W'(hit_idx_reg) + CNT_W'(1)
                                            : CNT_W'(SLOTS);
                    default: ;
                endcase
            end
        end
    end

    // Payload: request, sweep indexes and data, result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_mode_reg <= mode;
            req_addr_reg <= address;
            req_ku_reg   <= key_upper;
            req_kl_reg   <= key_lower;
            req_kind_reg <= key_kind;
            high_seq_reg <= '0;
        end
        else if (proc_en)
        begin
            case (req_mode_reg)
                MODE_LOOKUP, MODE_DELETE, MODE_NEXT:
                    if (!hit_reg && (req_mode_reg == MODE_NEXT ? proc_after : proc_match))
                    begin
                        hit_idx_reg  <= proc_idx;
                        hit_data_reg <= rd_data_reg;
                    end
                MODE_STORE:
                begin
                    if (!proc_valid)
                        empty_idx_reg <= proc_idx;
                    else
                    begin
                        if (proc_match)
                            amatch_idx_reg <= proc_idx;
                        if (rd_data_reg.seq_num > high_seq_reg)
                            high_seq_reg <= rd_data_reg.seq_num;
                        if (!low_reg || (rd_data_reg.seq_num < low_seq_reg))
                        begin
                            low_idx_reg <= proc_idx;
                            low_seq_reg <= rd_data_reg.seq_num;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (finish)
        begin
            found_reg           <= 1'b0;
            found_address_reg   <= '0;
            found_key_upper_reg <= '0;
            found_key_lower_reg <= '0;
            found_kind_reg      <= '0;
            slot_used_reg       <= '0;
            case (req_mode_reg)
                MODE_LOOKUP, MODE_NEXT:
                    if (hit_reg)
                    begin
                        found_reg           <= 1'b1;
                        found_address_reg   <= hit_data_reg.address;
                        found_key_upper_reg <= hit_data_reg.key_upper;
                        found_key_lower_reg <= hit_data_reg.key_lower;
                        found_kind_reg      <= hit_data_reg.kind;
                        slot_used_reg       <= SLOT_W'(hit_idx_reg);
                    end
                MODE_DELETE:
                    if (hit_reg)
                    begin
                        found_reg     <= 1'b1;
                        slot_used_reg <= SLOT_W'(hit_idx_reg);
                    end
                MODE_STORE:
                begin
                    found_reg     <= 1'b1;
                    slot_used_reg <= SLOT_W'(store_idx);
                end
                default: ;
            endcase
        end
    end

    assign done            = done_reg;
    assign found           = found_reg;
    assign found_address   = found_address_reg;
    assign found_key_upper = found_key_upper_reg;
    assign found_key_lower = found_key_lower_reg;
    assign found_kind      = found_kind_reg;
    assign slot_used       = slot_used_reg;

    // A result only follows the finish step, and the block is idle while it shows.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_FINISH) && !busy)
        else $error("result strobe without finish step");

    // Iterator never runs past the end of the table.
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= CNT_W'(SLOTS))
        else $error("iterator out of range");

    // A store always lands and leaves its slot valid.
    a_store_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish && (req_mode_reg == MODE_STORE) |=> done && found && valid_reg[$past(store_idx)])
        else $error("store did not leave a valid slot");

    // The sweep covers every slot before finishing.
    a_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (state_next == ST_FINISH) |-> cnt_reg == CNT_W'(SLOTS))
        else $error("sweep ended early");

endmodule
